[hw/rtl/q_encoding_word_decoder_assert.svh]
// ----------------------------------------------------------------------------
// Q-encoded word decoder assertion macros
// Concurrent assertion shorthands clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef Q_ENCODING_WORD_DECODER_ASSERT_SVH
`define Q_ENCODING_WORD_DECODER_ASSERT_SVH

// same-cycle implication
`define QEWD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qewd assertion failed");

// next-cycle implication
`define QEWD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qewd assertion failed");

`endif

[hw/rtl/qewd_pkg.sv]
// ----------------------------------------------------------------------------
// qewd_pkg
// Types, character codes and hex helpers for the Q-encoded word decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qewd_pkg;

  localparam logic [7:0] CHR_SPACE      = 8'h20;
  localparam logic [7:0] CHR_DEL        = 8'h7F;
  localparam logic [7:0] CHR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHR_EQUALS     = 8'h3D;

  // subtrahend per 32-character column of the code chart
  localparam logic [7:0] HEX_OFS [4] = '{8'h00, 8'h30, 8'h37, 8'h57};

  typedef enum logic [2:0] {
    PH_PLAIN = 3'b001,
    PH_HEX1  = 3'b010,
    PH_HEX2  = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] nibble;
    logic       err;
  } st_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       word_end;
    logic       word_error;
  } res_t;

  localparam st_t ST_RESET = '{phase: PH_PLAIN, nibble: 4'h0, err: 1'b0};

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = c - HEX_OFS[c[6:5]];
    return d[3:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/qewd_dec.sv]
// ----------------------------------------------------------------------------
// qewd_dec
// Per-character decode step: result fields and next escape state.
// ----------------------------------------------------------------------------
`default_nettype none

module qewd_dec (
  input  wire logic [7:0]     chr,
  input  wire logic           last,
  input  wire qewd_pkg::st_t  st,
  output qewd_pkg::st_t       st_nxt,
  output qewd_pkg::res_t      res
);
  import qewd_pkg::*;

  st_t upd;

  always_comb begin
    upd = st;
    res = '0;
    if (!st.err) begin
      unique case (st.phase)
        PH_HEX1: begin
          if (is_hex(chr)) begin
            upd.nibble = hex_val(chr);
            upd.phase  = PH_HEX2;
          end else begin
            upd.err   = 1'b1;
            upd.phase = PH_PLAIN;
          end
        end
        PH_HEX2: begin
          if (is_hex(chr)) begin
            res.data       = {st.nibble, hex_val(chr)};
            res.byte_valid = 1'b1;
          end else begin
            upd.err = 1'b1;
          end
          upd.phase = PH_PLAIN;
        end
        default: begin
          upd.phase = PH_PLAIN;
          priority if (chr == CHR_UNDERSCORE) begin
            res.data       = CHR_SPACE;
            res.byte_valid = 1'b1;
          end else if (chr == CHR_EQUALS) begin
            upd.phase = PH_HEX1;
          end else if (chr > CHR_SPACE && chr < CHR_DEL) begin
            res.data       = chr;
            res.byte_valid = 1'b1;
          end else begin
            upd.err = 1'b1;
          end
        end
      endcase
    end

    // close the word: report status, start the next word clean
    st_nxt = upd;
    if (last) begin
      res.word_end   = 1'b1;
      res.word_error = upd.err || (upd.phase != PH_PLAIN);
      st_nxt         = ST_RESET;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/q_encoding_word_decoder.sv]
// ----------------------------------------------------------------------------
// q_encoding_word_decoder
// Decodes the payload of a Q-encoded word, one character per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: in_tdata carries one raw character, in_tlast marks the
//   final character of the word. Every input item gives exactly one result.
//   Output stream: out_tdata is the decoded byte (zero when none),
//   out_tuser[0] flags a decoded byte, out_tlast marks word end and
//   out_tuser[1] gives the word's error status on that item.
//   Pipeline: each item passes the input register, then the result
//   register; a stall at the output can hold it in either. Throughput: one
//   item per cycle while the receiver takes every result, set by the
//   escape state update between the two registers.
//   Reset clears both stages and the escape state; the first character
//   after reset starts a new word.
//   When the receiver stalls, the result register holds its item and the
//   input register takes one more item; after that in_tready drops until
//   the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module q_encoding_word_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic [1:0]      out_tuser,  // [0] byte_valid, [1] word_error
  output logic            out_tlast
);
  import qewd_pkg::*;

  logic       s1_vld_r, s1_vld_nxt;
  logic [7:0] s1_chr_r;
  logic       s1_last_r;
  logic       s1_adv;

  st_t        st_r, st_nxt;
  res_t       res;
  logic       out_vld_r, out_vld_nxt;
  res_t       out_r;

  qewd_dec u_dec (
    .chr    (s1_chr_r),
    .last   (s1_last_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_tready) begin
      s1_vld_nxt = in_tvalid;
    end
    out_vld_nxt = out_vld_r;
    if (s1_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= ST_RESET;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (s1_adv) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_chr_r  <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r.data;
  assign out_tuser  = {out_r.word_error, out_r.byte_valid};
  assign out_tlast  = out_r.word_end;

  `include "q_encoding_word_decoder_assert.svh"

  `QEWD_ASSERT_NOW(a_err_only_at_end, out_tvalid && !out_tlast, !out_tuser[1])
  `QEWD_ASSERT_NOW(a_no_byte_zero, out_tvalid && !out_tuser[0], out_tdata == 8'h00)
  `QEWD_ASSERT_NEXT(a_word_end_clears, s1_adv && s1_last_r,
                    st_r.phase == PH_PLAIN && !st_r.err && st_r.nibble == 4'h0)
  `QEWD_ASSERT_NOW(a_err_parks_plain, st_r.err, st_r.phase == PH_PLAIN)

endmodule

`default_nettype wire

[bench/q_encoding_word_decoder_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// q_encoding_word_decoder_tb
// Drives encoded-word characters into the decoder and checks every decoded
// item against a behavioral decoder kept in the bench. Directed words cover
// the plain, underscore and escape paths, bad bytes and broken escapes.
// Random words, mostly well formed with some noise, follow. Both sides of
// the stream idle at random.
// ----------------------------------------------------------------------------

module q_encoding_word_decoder_tb;
  import qewd_pkg::*;

  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 200_000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  // decoder state mirrored in the bench
  phase_t     esc_phase = PH_PLAIN;
  logic [3:0] esc_nibble = 4'h0;
  logic       word_bad = 1'b0;

  res_t decoded_q[$];
  int   sent_count = 0;
  int   fail_count = 0;
  int   cycle_count = 0;
  logic steady = 1'b0;

  q_encoding_word_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 30);
  end

  function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] v);
    v = 4'h0;
    if (c >= "0" && c <= "9") begin
      v = c[3:0];
    end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
      v = c[3:0] + 4'd9;
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic res_t decode_char(input logic [7:0] c, input logic last);
    res_t       r;
    logic [3:0] v;
    r = '0;
    if (!word_bad) begin
      case (esc_phase)
        PH_HEX1: begin
          if (hex_digit(c, v)) begin
            esc_nibble = v;
            esc_phase  = PH_HEX2;
          end else begin
            word_bad  = 1'b1;
            esc_phase = PH_PLAIN;
          end
        end
        PH_HEX2: begin
          if (hex_digit(c, v)) begin
            r.data       = {esc_nibble, v};
            r.byte_valid = 1'b1;
          end else begin
            word_bad = 1'b1;
          end
          esc_phase = PH_PLAIN;
        end
        default: begin
          esc_phase = PH_PLAIN;
          if (c == CHR_UNDERSCORE) begin
            r.data       = CHR_SPACE;
            r.byte_valid = 1'b1;
          end else if (c == CHR_EQUALS) begin
            esc_phase = PH_HEX1;
          end else if (c > CHR_SPACE && c < CHR_DEL) begin
            r.data       = c;
            r.byte_valid = 1'b1;
          end else begin
            word_bad = 1'b1;
          end
        end
      endcase
    end
    if (last) begin
      r.word_end   = 1'b1;
      r.word_error = word_bad || (esc_phase != PH_PLAIN);
      esc_phase    = PH_PLAIN;
      esc_nibble   = 4'h0;
      word_bad     = 1'b0;
    end
    return r;
  endfunction

  // entered and left at a falling edge; in_tvalid stays high for the next item
  task automatic send_char(input logic [7:0] c, input logic last);
    if (!steady) begin
      while ($urandom_range(0, 99) < 30) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decoded_q = {decoded_q, decode_char(c, last)};
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_word(input logic [7:0] w[$]);
    foreach (w[i]) send_char(w[i], i == w.size() - 1);
  endtask

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(8'h30 + v);
    return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
  endfunction

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        $error("result with nothing expected: byte %0h user %0b last %0b",
               out_tdata, out_tuser, out_tlast);
        fail_count++;
      end else begin
        want = decoded_q.pop_front();
        if (out_tdata !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_tdata);
          fail_count++;
        end
        if (out_tuser[0] !== want.byte_valid) begin
          $error("byte_valid: expected %0b, got %0b", want.byte_valid, out_tuser[0]);
          fail_count++;
        end
        if (out_tlast !== want.word_end) begin
          $error("word_end: expected %0b, got %0b", want.word_end, out_tlast);
          fail_count++;
        end
        if (out_tuser[1] !== want.word_error) begin
          $error("word_error: expected %0b, got %0b", want.word_error, out_tuser[1]);
          fail_count++;
        end
      end
    end
  end

  // printable extremes, underscore, escapes in both cases, 0x00 and 0xFF bytes
  task automatic test_plain_and_escapes();
    send_word('{"A", "~", "!", "_", "=", "a", "0"});
    send_word('{"=", "f", "F"});
    send_word('{"=", "0", "0"});
  endtask

  // space, DEL, high and control bytes; the rest of the word is swallowed
  task automatic test_bad_bytes();
    send_word('{CHR_SPACE, "A"});
    send_word('{CHR_DEL});
    send_word('{8'h80, 8'hFF, 8'h00});
  endtask

  // non-hex digit in either escape position, escape cut off by word end
  task automatic test_broken_escapes();
    send_word('{"=", "G", "B"});
    send_word('{"=", "4", "z"});
    send_word('{"="});
    send_word('{"=", "9"});
  endtask

  task automatic test_random_words();
    logic [7:0] w[$];
    int         len;
    int         pick;
    int         start;
    start = sent_count;
    while (sent_count - start < RANDOM_ITEMS) begin
      // hold a long stretch with both sides always ready
      steady = (sent_count - start >= 700) && (sent_count - start < 1000);
      w.delete();
      len = $urandom_range(1, 10);
      repeat (len) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          w = {w, 8'($urandom_range(8'h21, 8'h7E))};
        end else if (pick < 52) begin
          w = {w, CHR_UNDERSCORE};
        end else if (pick < 90) begin
          w = {w, CHR_EQUALS};
          w = {w, rand_hex_char()};
          w = {w, rand_hex_char()};
          // corrupt one escape digit now and then
          if ($urandom_range(0, 29) == 0)
            w[w.size() - 1 - $urandom_range(0, 1)] = 8'($urandom_range(0, 255));
        end else begin
          w = {w, 8'($urandom_range(0, 255))};
        end
      end
      // cut an escape off at word end
      if ($urandom_range(0, 9) == 0) begin
        w = {w, CHR_EQUALS};
        if ($urandom_range(0, 1)) w = {w, rand_hex_char()};
      end
      send_word(w);
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_plain_and_escapes();
    test_bad_bytes();
    test_broken_escapes();
    test_random_words();
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
